>>> hdl/paid_pkg.sv
// Shared types and constants for the positional array insert/delete block.
`timescale 1ns / 1ps
`default_nettype none

package paid_pkg;

  // Field widths of the request and result items.
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned ST_W      = 2;
  localparam int unsigned FILL_W    = 7;
  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 48;

  // Request command codes.
  typedef enum logic [CMD_W-1:0] {
    OP_TRAVERSE  = 3'd0,
    OP_INS_POS   = 3'd1,
    OP_INS_FRONT = 3'd2,
    OP_INS_END   = 3'd3,
    OP_DEL_POS   = 3'd4,
    OP_DEL_FRONT = 3'd5,
    OP_DEL_END   = 3'd6,
    OP_NOP       = 3'd7
  } op_e;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // Walk pointer updates.
  typedef enum logic [2:0] {
    PTR_HOLD   = 3'd0,
    PTR_ZERO   = 3'd1,
    PTR_CNT_M1 = 3'd2,
    PTR_TGT_P1 = 3'd3,
    PTR_INC    = 3'd4,
    PTR_DEC    = 3'd5
  } ptr_op_e;

  // Memory write selection.
  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_UP   = 2'd1,
    WR_DOWN = 2'd2,
    WR_NEW  = 2'd3
  } wr_op_e;

  // Element count updates.
  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_op_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic    capture;
    ptr_op_e ptr_op;
    wr_op_e  wr_op;
    cnt_op_e cnt_op;
    logic    out_ld;
    logic    out_trav;
    status_e out_st;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic full;
    logic empty;
    logic ins_pos_ok;
    logic del_pos_ok;
    logic ins_shift;
    logic del_shift;
    logic ptr_at_end;
    logic shup_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> hdl/paid_ctrl.sv
// Controller state machine sequencing the list edits and the traverse walk.
`timescale 1ns / 1ps
`default_nettype none

module paid_ctrl
  import paid_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic [CMD_W-1:0] req_cmd_i,
  output logic             req_ready_o,
  input  dp_sts_t          sts_i,
  output dp_cmd_t          cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRAV,
    S_SHUP,
    S_SHDN,
    S_INS_FIN,
    S_DEL_FIN,
    S_RESP
  } state_e;

  state_e  state_q, state_d;
  status_e resp_st_q, resp_st_d;
  op_e     op;
  logic    accept;

  assign op          = op_e'(req_cmd_i);
  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d          = state_q;
    resp_st_d        = resp_st_q;
    cmd_o            = '0;
    cmd_o.ptr_op     = PTR_HOLD;
    cmd_o.wr_op      = WR_NONE;
    cmd_o.cnt_op     = CNT_HOLD;
    cmd_o.out_st     = ST_OK;
    cmd_o.capture    = accept;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_TRAVERSE: begin
              if (sts_i.empty) begin
                resp_st_d = ST_EMPTY;
                state_d   = S_RESP;
              end else begin
                cmd_o.ptr_op = PTR_ZERO;
                state_d      = S_TRAV;
              end
            end
            OP_INS_POS, OP_INS_FRONT, OP_INS_END: begin
              if (sts_i.full) begin
                resp_st_d = ST_FULL;
                state_d   = S_RESP;
              end else if (op == OP_INS_POS && !sts_i.ins_pos_ok) begin
                resp_st_d = ST_BADPOS;
                state_d   = S_RESP;
              end else if (sts_i.ins_shift) begin
                cmd_o.ptr_op = PTR_CNT_M1;
                state_d      = S_SHUP;
              end else begin
                state_d = S_INS_FIN;
              end
            end
            OP_DEL_POS, OP_DEL_FRONT, OP_DEL_END: begin
              if (sts_i.empty) begin
                resp_st_d = ST_EMPTY;
                state_d   = S_RESP;
              end else if (op == OP_DEL_POS && !sts_i.del_pos_ok) begin
                resp_st_d = ST_BADPOS;
                state_d   = S_RESP;
              end else if (sts_i.del_shift) begin
                cmd_o.ptr_op = PTR_TGT_P1;
                state_d      = S_SHDN;
              end else begin
                state_d = S_DEL_FIN;
              end
            end
            default: begin
              resp_st_d = ST_OK;
              state_d   = S_RESP;
            end
          endcase
        end
      end
      S_TRAV: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_trav = 1'b1;
          if (sts_i.ptr_at_end) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.ptr_op = PTR_INC;
          end
        end
      end
      S_SHUP: begin
        cmd_o.wr_op = WR_UP;
        if (sts_i.shup_done) begin
          state_d = S_INS_FIN;
        end else begin
          cmd_o.ptr_op = PTR_DEC;
        end
      end
      S_SHDN: begin
        cmd_o.wr_op = WR_DOWN;
        if (sts_i.ptr_at_end) begin
          state_d = S_DEL_FIN;
        end else begin
          cmd_o.ptr_op = PTR_INC;
        end
      end
      S_INS_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.wr_op  = WR_NEW;
          cmd_o.cnt_op = CNT_INC;
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_DEL_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.cnt_op = CNT_DEC;
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          cmd_o.out_st = resp_st_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      resp_st_q <= ST_OK;
    end else begin
      state_q   <= state_d;
      resp_st_q <= resp_st_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/paid_dp.sv
// Datapath: element memory, count, walk pointer and result register.
`timescale 1ns / 1ps
`default_nettype none

module paid_dp
  import paid_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CMD_W-1:0]  req_cmd_i,
  input  logic [POS_W-1:0]  req_pos_i,
  input  logic [VAL_W-1:0]  req_val_i,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic [ST_W-1:0]   res_status_o,
  output logic [VAL_W-1:0]  res_element_o,
  output logic [FILL_W-1:0] res_fill_o,
  output logic              res_last_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned XW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    ptr_q, ptr_d;
  logic [CW-1:0]    tgt_q, tgt_d;
  logic [VAL_W-1:0] val_q;

  logic [XW-1:0]    pos_x, cnt_x, pos_m1;
  logic [CW:0]      tgt_p1_x, ptr_p1_x, cnt_xx;
  logic [CW-1:0]    ptr_up, ptr_dn, cnt_m1, tgt_p1;
  logic [CW+FILL_W-1:0] fill_x;
  logic             we;
  logic [IW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;

  logic             out_valid_q;
  logic [ST_W-1:0]  out_st_q;
  logic [VAL_W-1:0] out_elem_q;
  logic [FILL_W-1:0] out_fill_q;
  logic             out_last_q;

  assign pos_x    = {{(XW-POS_W){1'b0}}, req_pos_i};
  assign cnt_x    = {{(XW-CW){1'b0}}, cnt_q};
  assign pos_m1   = pos_x - 1'b1;
  assign ptr_up   = ptr_q + 1'b1;
  assign ptr_dn   = ptr_q - 1'b1;
  assign cnt_m1   = cnt_q - 1'b1;
  assign tgt_p1   = tgt_d + 1'b1;
  assign tgt_p1_x = {1'b0, tgt_d} + 1'b1;
  assign ptr_p1_x = {1'b0, ptr_q} + 1'b1;
  assign cnt_xx   = {1'b0, cnt_q};

  // Target index of the edit, from the request fields.
  always_comb begin
    case (op_e'(req_cmd_i))
      OP_INS_POS, OP_DEL_POS: tgt_d = pos_m1[CW-1:0];
      OP_INS_END:             tgt_d = cnt_q;
      OP_DEL_END:             tgt_d = cnt_m1;
      default:                tgt_d = '0;
    endcase
  end

  always_comb begin
    sts_o.full       = (cnt_q == DEPTH_C);
    sts_o.empty      = (cnt_q == '0);
    sts_o.ins_pos_ok = (pos_x != '0) && (pos_x <= cnt_x + 1'b1);
    sts_o.del_pos_ok = (pos_x != '0) && (pos_x <= cnt_x);
    sts_o.ins_shift  = (cnt_q > tgt_d);
    sts_o.del_shift  = (tgt_p1_x < cnt_xx);
    sts_o.ptr_at_end = (ptr_p1_x == cnt_xx);
    sts_o.shup_done  = (ptr_q == tgt_q);
    sts_o.out_free   = !out_valid_q || res_ready_i;
  end

  always_comb begin
    case (cmd_i.ptr_op)
      PTR_ZERO:   ptr_d = '0;
      PTR_CNT_M1: ptr_d = cnt_m1;
      PTR_TGT_P1: ptr_d = tgt_p1;
      PTR_INC:    ptr_d = ptr_up;
      PTR_DEC:    ptr_d = ptr_dn;
      default:    ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    case (cmd_i.cnt_op)
      CNT_INC: cnt_d = cnt_q + 1'b1;
      CNT_DEC: cnt_d = cnt_m1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_comb begin
    we    = 1'b1;
    wdata = rdata_q;
    case (cmd_i.wr_op)
      WR_UP:   waddr = ptr_up[IW-1:0];
      WR_DOWN: waddr = ptr_dn[IW-1:0];
      WR_NEW: begin
        waddr = tgt_q[IW-1:0];
        wdata = val_q;
      end
      default: begin
        we    = 1'b0;
        waddr = '0;
      end
    endcase
  end

  // The read follows the next pointer, so rdata_q always holds the entry
  // at the current pointer.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[ptr_d[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tgt_q <= tgt_d;
      val_q <= req_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ptr_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
    end
  end

  assign fill_x = {{FILL_W{1'b0}}, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_st_q   <= cmd_i.out_st;
      out_elem_q <= cmd_i.out_trav ? rdata_q : '0;
      out_fill_q <= fill_x[FILL_W-1:0];
      out_last_q <= cmd_i.out_trav ? sts_o.ptr_at_end : 1'b1;
    end
  end

  assign res_valid_o   = out_valid_q;
  assign res_status_o  = out_st_q;
  assign res_element_o = out_elem_q;
  assign res_fill_o    = out_fill_q;
  assign res_last_o    = out_last_q;

endmodule

`default_nettype wire

>>> hdl/positional_array_insert_delete_top.sv
// Top level of the positional array insert/delete block.
`timescale 1ns / 1ps
`default_nettype none

// Sequence: a rejected request, a traverse of an empty list or an unused command goes
// through the response state to the result register; an insert or a delete first shifts
// the later elements, one element moved per cycle, then finishes and loads its result.
// Throughput: one request at a time; a traverse lists one element per cycle while the
// result side accepts, set by the single read port of the element memory and the one-entry result register.
// Reset clears the element count and the handshake state; the memory is not cleared.

module positional_array_insert_delete_top
  import paid_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Request channel.
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // From bit 0: command[2:0], position[9:3], value[41:10], zero padding[47:42].
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // Result channel.
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // From bit 0: status[1:0], element[33:2], fill_count[40:34], zero padding[47:41].
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  // Marks the final result caused by a request.
  output logic                 m_axis_tlast_o
);

  // Request fields, unpacked from the lowest bit upwards.
  logic [CMD_W-1:0]  req_cmd;
  logic [POS_W-1:0]  req_pos;
  logic [VAL_W-1:0]  req_val;

  // Result fields held in the datapath's output register.
  logic [ST_W-1:0]   res_status;
  logic [VAL_W-1:0]  res_element;
  logic [FILL_W-1:0] res_fill;

  // Command and status between the controller and the datapath.
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  assign req_cmd = s_axis_tdata_i[CMD_W-1:0];
  assign req_pos = s_axis_tdata_i[CMD_W+POS_W-1:CMD_W];
  assign req_val = s_axis_tdata_i[CMD_W+POS_W+VAL_W-1:CMD_W+POS_W];

  // The controller takes a request only when idle and then steps the datapath
  // through the shift walk or the traverse until the final result is loaded.
  paid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_cmd_i   (req_cmd),
    .req_ready_o (s_axis_tready_o),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  // The datapath owns the element memory, the count, the walk pointer and the
  // result register, which decouples the result side from the walk.
  paid_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_cmd_i     (req_cmd),
    .req_pos_i     (req_pos),
    .req_val_i     (req_val),
    .cmd_i         (dp_cmd),
    .sts_o         (dp_sts),
    .res_valid_o   (m_axis_tvalid_o),
    .res_ready_i   (m_axis_tready_i),
    .res_status_o  (res_status),
    .res_element_o (res_element),
    .res_fill_o    (res_fill),
    .res_last_o    (m_axis_tlast_o)
  );

  // Pack the result fields, lowest field first, and pad to whole bytes.
  assign m_axis_tdata_o = {{(M_TDATA_W-ST_W-VAL_W-FILL_W){1'b0}}, res_fill, res_element,
                           res_status};

endmodule

`default_nettype wire
